// ----- design/dpt_pkg.sv -----
// Shared types and constants for the date pattern translator.
// Used by dpt_front, dpt_queue, dpt_back and date_pattern_translator.
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

  localparam logic [7:0] QUOTE   = 8'h27;
  localparam logic [7:0] PERCENT = 8'h25;
  localparam int unsigned MAX_OUT = 4;
  localparam int unsigned QDEPTH  = 2;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_UNCLOSED    = 2'd2
  } status_t;

  // One translated input item: up to four bytes plus end and status marks.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              nres;
    logic                    has_chars;
    logic                    final_item;
    status_t                 status;
  } rec_t;

endpackage

`default_nettype wire

// ----- design/date_pattern_translator.sv -----
// Date pattern translator: datetime pattern bytes in, strftime bytes out.
// A result is written to the record queue and then to the output register.
// Throughput: one input byte per cycle while the queue has room; the back
// part delivers one result per cycle while the user pops each one.
// Reset (synchronous, rst high) clears the pattern state, queue and output.
// Depends on dpt_pkg, dpt_front, dpt_queue and dpt_back.
`timescale 1ns / 1ps
`default_nettype none

module date_pattern_translator (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pattern_char,
  input  logic       is_final,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       end_of_pattern,
  output logic [1:0] status
);
  import dpt_pkg::*;

  rec_t q_wdata;
  rec_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  dpt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pattern_char (pattern_char),
    .is_final     (is_final),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  dpt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dpt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_char       (out_char),
    .char_valid     (char_valid),
    .end_of_pattern (end_of_pattern),
    .status         (status)
  );

  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != ST_OK)) |-> end_of_pattern)
    else $error("nonzero status on a result that does not end the pattern");

  a_status_only_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !char_valid) |-> (end_of_pattern && (out_char == 8'h00)))
    else $error("status-only result is not the final one or carries a byte");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_pop_without_transfer_holds: assert property (@(posedge clk) disable iff (rst)
    (q_empty && !empty && !pop) |=> !empty)
    else $error("waiting result lost without a transfer");

endmodule

`default_nettype wire

// ----- design/dpt_front.sv -----
// Front part: accepts pattern bytes, tracks run and literal state and
// builds one record of output bytes per input byte. Depends on dpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    pattern_char,
  input  logic          is_final,
  output logic          q_push,
  output dpt_pkg::rec_t q_data,
  input  logic          q_full
);
  import dpt_pkg::*;

  typedef struct packed {
    logic                    il;
    logic                    qp;
    logic [7:0]              rl;
    logic [2:0]              rlen;
    status_t                 err;
    logic [2:0]              ocnt;
    logic [MAX_OUT-1:0][7:0] obuf;
  } st_t;

  logic       inside_literal;
  logic       quote_pending;
  logic [7:0] run_letter;
  logic [2:0] run_length;
  status_t    error_code;
  logic       accept;
  st_t        s_in;
  st_t        s_out;

  function automatic logic [7:0] directive_of(logic [7:0] letter, logic [2:0] len);
    logic [7:0] d;
    d = 8'h00;
    if (letter == "y") begin
      if (len == 3'd4) d = "Y";
      else if (len == 3'd2) d = "y";
    end else if (len == 3'd2) begin
      unique case (letter)
        "M":     d = "m";
        "d":     d = "d";
        "H":     d = "H";
        "m":     d = "M";
        "s":     d = "S";
        default: d = 8'h00;
      endcase
    end
    return d;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic st_t f_emit(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    if ((r.err == ST_OK) && (r.ocnt < 3'(MAX_OUT))) begin
      r.obuf[r.ocnt[1:0]] = c;
      r.ocnt = r.ocnt + 3'd1;
    end
    return r;
  endfunction

  function automatic st_t f_emit_lit(st_t s, logic [7:0] c);
    st_t r;
    r = f_emit(s, c);
    if (c == PERCENT) r = f_emit(r, PERCENT);
    return r;
  endfunction

  function automatic st_t f_flush(st_t s);
    st_t        r;
    logic [7:0] d;
    r = s;
    d = directive_of(s.rl, s.rlen);
    if (s.rlen != 3'd0) begin
      if (d != 8'h00) begin
        r = f_emit(r, PERCENT);
        r = f_emit(r, d);
      end else if (r.err == ST_OK) begin
        r.err = ST_UNSUPPORTED;
      end
      r.rl = 8'h00;
      r.rlen = 3'd0;
    end
    return r;
  endfunction

  function automatic st_t f_plain(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    if (c == QUOTE) begin
      r = f_flush(r);
      r.qp = 1'b1;
    end else if (is_letter(c)) begin
      if ((r.rlen != 3'd0) && (r.rl == c)) begin
        if (r.rlen < 3'd5) r.rlen = r.rlen + 3'd1;
      end else begin
        r = f_flush(r);
        r.rl = c;
        r.rlen = 3'd1;
      end
    end else begin
      r = f_flush(r);
      r = f_emit_lit(r, c);
    end
    return r;
  endfunction

  always_comb begin
    s_in = '{il: inside_literal, qp: quote_pending, rl: run_letter, rlen: run_length,
             err: error_code, ocnt: 3'd0, obuf: '0};
    s_out = s_in;
    if (s_in.err == ST_OK) begin
      if (s_in.qp) begin
        s_out.qp = 1'b0;
        if (pattern_char == QUOTE) begin
          s_out = f_emit_lit(s_out, QUOTE);
        end else if (s_in.il) begin
          s_out.il = 1'b0;
          s_out = f_plain(s_out, pattern_char);
        end else begin
          s_out.il = 1'b1;
          s_out = f_emit_lit(s_out, pattern_char);
        end
      end else if (s_in.il) begin
        if (pattern_char == QUOTE) s_out.qp = 1'b1;
        else s_out = f_emit_lit(s_out, pattern_char);
      end else begin
        s_out = f_plain(s_out, pattern_char);
      end
    end
    if (is_final && (s_out.err == ST_OK)) begin
      s_out = f_flush(s_out);
      if ((s_out.il != s_out.qp) && (s_out.err == ST_OK)) s_out.err = ST_UNCLOSED;
    end
  end

  always_comb begin
    q_data.bytes      = s_out.obuf;
    q_data.has_chars  = (s_out.ocnt != 3'd0);
    q_data.nres       = (is_final && (s_out.ocnt == 3'd0)) ? 3'd1 : s_out.ocnt;
    q_data.final_item = is_final;
    q_data.status     = s_out.err;
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (q_data.nres != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_literal <= 1'b0;
      quote_pending  <= 1'b0;
      run_letter     <= 8'h00;
      run_length     <= 3'd0;
      error_code     <= ST_OK;
    end else if (accept) begin
      if (is_final) begin
        inside_literal <= 1'b0;
        quote_pending  <= 1'b0;
        run_letter     <= 8'h00;
        run_length     <= 3'd0;
        error_code     <= ST_OK;
      end else begin
        inside_literal <= s_out.il;
        quote_pending  <= s_out.qp;
        run_letter     <= s_out.rl;
        run_length     <= s_out.rlen;
        error_code     <= s_out.err;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/dpt_queue.sv -----
// Short record queue between the front and back parts.
// Depends on dpt_pkg for the record type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dpt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dpt_pkg::rec_t wdata,
  output logic          full,
  input  logic          pop,
  output dpt_pkg::rec_t rdata,
  output logic          empty
);
  import dpt_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  rec_t              mem [QDEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [PW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (PW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/dpt_back.sv -----
// Back part: walks the bytes of each record and presents one result at a
// time in an output register. Depends on dpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  dpt_pkg::rec_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_char,
  output logic          char_valid,
  output logic          end_of_pattern,
  output logic [1:0]    status
);
  import dpt_pkg::*;

  logic [1:0] idx;
  logic       ovalid;
  logic       load;
  logic       last;

  assign last  = ({1'b0, idx} == (q_data.nres - 3'd1));
  assign load  = !q_empty && (q_data.nres != 3'd0) && (!ovalid || pop);
  assign q_pop = !q_empty && ((q_data.nres == 3'd0) || (load && last));
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= 2'd0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char       <= q_data.has_chars ? q_data.bytes[idx] : 8'h00;
      char_valid     <= q_data.has_chars;
      end_of_pattern <= q_data.final_item && last;
      status         <= (q_data.final_item && last) ? q_data.status : ST_OK;
    end
  end

endmodule

`default_nettype wire
